@@ rtl/imtr_pkg.sv @@
// imtr_pkg: shared constants and types for the interval map.
// No dependencies.
package imtr_pkg;
    localparam int TableDepth = 256;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int FrameW = 31;
    localparam int EntryW = 31 + 31 + 64 + 4 + 32;
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    typedef struct packed {
        logic [30:0] first;
        logic [30:0] last;
        logic [63:0] handle;
        logic [3:0]  prot;
        logic [31:0] flags;
    } entry_t;
endpackage

@@ rtl/imtr_ram.sv @@
// imtr_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
module imtr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/interval_map_track_release.sv @@
// interval_map_track_release: sorted interval table, track and release.
// Depends on imtr_pkg and imtr_ram.
//
//  channel   dir  fields
//  s_axis    in   tdata: first_frame, last_frame, handle, protection, map_flags
//                 tuser: action
//  m_axis    out  tdata: status, entry_count
//  cfg       in   wdata: windows_mode
//
// One item at a time. The search scans the entries in turn; a move shifts each
// entry with a read state and then a write state, as the single RAM (one read,
// one write per cycle with registered read) needs a read then a write.
// Reset clears the entry count and mode; no clearing pass. The result goes to an
// output register; a request holds in its last state while an older result waits.
module interval_map_track_release (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // first_frame, last_frame, handle, protection, map_flags
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,  // status, entry_count
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_wdata
);
    import imtr_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FCHK   = 5'd2;   // search: check
    localparam logic [4:0] S_TPREV  = 5'd3;   // track: read i-1
    localparam logic [4:0] S_TNEXT  = 5'd4;   // track: read i
    localparam logic [4:0] S_TDEC   = 5'd5;
    localparam logic [4:0] S_MVRD   = 5'd6;   // move: issue read
    localparam logic [4:0] S_MVWR   = 5'd7;   // move: write
    localparam logic [4:0] S_WR     = 5'd8;   // single write then done
    localparam logic [4:0] S_RL     = 5'd9;   // release: read l
    localparam logic [4:0] S_RLCHK  = 5'd10;
    localparam logic [4:0] S_RR     = 5'd11;  // release: read r
    localparam logic [4:0] S_RRCHK  = 5'd12;
    localparam logic [4:0] S_RRDEC  = 5'd13;  // read r-1
    localparam logic [4:0] S_RDEC   = 5'd14;
    localparam logic [4:0] S_RWL    = 5'd15;  // write trimmed l
    localparam logic [4:0] S_RWR    = 5'd16;  // write trimmed r
    localparam logic [4:0] S_SPLIT  = 5'd17;  // remove l..r
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] state_reg, state_next;
    logic wmode_reg;
    logic [CntW-1:0] used_reg, used_next;
    logic act_reg;
    logic [30:0] x_reg, y_reg;
    logic [63:0] h_reg;
    logic [3:0] p_reg;
    logic [31:0] f_reg;
    logic [CntW-1:0] k_reg, k_next;       // scan pointer
    logic frame_sel_reg, frame_sel_next;  // 0 search x, 1 search y
    logic [CntW-1:0] i_reg, i_next;       // l / i
    logic [CntW-1:0] r_reg, r_next;
    logic [CntW-1:0] mend_reg, mend_next; // move bookkeeping
    logic [CntW-1:0] mcnt_reg, mcnt_next;
    logic mup_reg, mup_next;              // 1 open slot, 0 remove
    logic [4:0] ret_reg, ret_next;        // state after move
    entry_t a_reg, a_next;                // held entry (l / prev)
    entry_t b_reg, b_next;                // held entry (r / next)
    entry_t w_reg, w_next;                // pending write
    logic [CntW-1:0] wa_reg, wa_next;
    logic [1:0] status_reg, status_next;
    logic out_valid_reg;
    logic [15:0] out_data_reg;
    logic out_load;

    logic we;
    logic [IdxW-1:0] waddr, raddr;
    entry_t wdata, rdata;
    logic [EntryW-1:0] rbits;

    imtr_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rbits)
    );
    assign rdata = entry_t'(rbits);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    logic [30:0] sframe;
    logic same_a, same_b;
    assign sframe = frame_sel_reg ? y_reg : x_reg;
    assign same_a = (a_reg.handle == h_reg) && (a_reg.prot == p_reg) && (a_reg.flags == f_reg);
    assign same_b = (rdata.handle == h_reg) && (rdata.prot == p_reg) && (rdata.flags == f_reg);

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        k_next = k_reg;
        frame_sel_next = frame_sel_reg;
        i_next = i_reg;
        r_next = r_reg;
        mend_next = mend_reg;
        mcnt_next = mcnt_reg;
        mup_next = mup_reg;
        ret_next = ret_reg;
        a_next = a_reg;
        b_next = b_reg;
        w_next = w_reg;
        wa_next = wa_reg;
        status_next = status_reg;
        we = 1'b0;
        waddr = IdxW'(wa_reg);
        wdata = w_reg;
        raddr = IdxW'(k_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                frame_sel_next = 1'b0;
                raddr = '0;
            end
            S_FCHK:
            begin
                if (k_reg >= used_reg || rdata.last >= sframe)
                begin
                    if (frame_sel_reg)
                    begin
                        r_next = k_reg;
                        raddr = IdxW'(k_reg);
                        state_next = S_RRCHK;
                    end
                    else if (!act_reg)
                    begin
                        i_next = k_reg;
                        raddr = IdxW'(k_reg - 1'b1);
                        state_next = S_TPREV;
                    end
                    else
                    begin
                        i_next = k_reg;
                        raddr = IdxW'(k_reg);
                        state_next = S_RLCHK;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    raddr = IdxW'(k_reg + 1'b1);
                    state_next = S_FCHK;
                end
            end
            S_TPREV:
            begin
                a_next = rdata;
                raddr = IdxW'(i_reg);
                state_next = S_TNEXT;
            end
            S_TNEXT:
            begin
                state_next = S_TDEC;
            end
            S_TDEC:
            begin
                b_next = rdata;
                if (i_reg != '0 && {1'b0, x_reg} == {1'b0, a_reg.last} + 32'd1 && same_a)
                begin
                    w_next = a_reg;
                    w_next.last = y_reg;
                    wa_next = i_reg - 1'b1;
                    if (i_reg < used_reg && {1'b0, y_reg} + 32'd1 == {1'b0, rdata.first}
                        && same_b)
                    begin
                        w_next.last = rdata.last;
                        mup_next = 1'b0;
                        mcnt_next = CntW'(1);
                        k_next = i_reg;
                        mend_next = used_reg - 1'b1;
                        ret_next = S_WR;
                        state_next = S_MVRD;
                    end
                    else
                    begin
                        state_next = S_WR;
                    end
                end
                else if (i_reg < used_reg && {1'b0, y_reg} + 32'd1 == {1'b0, rdata.first}
                         && same_b)
                begin
                    w_next = rdata;
                    w_next.first = x_reg;
                    wa_next = i_reg;
                    state_next = S_WR;
                end
                else if (used_reg >= CntW'(TableDepth))
                begin
                    status_next = ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    w_next = '{first: x_reg, last: y_reg, handle: h_reg,
                               prot: p_reg, flags: f_reg};
                    wa_next = i_reg;
                    mup_next = 1'b1;
                    k_next = used_reg;
                    mend_next = i_reg;
                    ret_next = S_WR;
                    state_next = S_MVRD;
                end
            end
            S_MVRD:
            begin
                // up: k from used down to mend+1, copy k-1 -> k
                // down: k from pos while k+cnt < used, copy k+cnt -> k
                if (mup_reg)
                begin
                    if (k_reg > mend_reg)
                    begin
                        raddr = IdxW'(k_reg - 1'b1);
                        state_next = S_MVWR;
                    end
                    else
                    begin
                        used_next = used_reg + 1'b1;
                        state_next = ret_reg;
                    end
                end
                else
                begin
                    if (k_reg + mcnt_reg < used_reg)
                    begin
                        raddr = IdxW'(k_reg + mcnt_reg);
                        state_next = S_MVWR;
                    end
                    else
                    begin
                        used_next = used_reg - mcnt_reg;
                        state_next = ret_reg;
                    end
                end
            end
            S_MVWR:
            begin
                we = 1'b1;
                waddr = IdxW'(k_reg);
                wdata = rdata;
                k_next = mup_reg ? k_reg - 1'b1 : k_reg + 1'b1;
                state_next = S_MVRD;
            end
            S_WR:
            begin
                we = 1'b1;
                state_next = S_OUT;
            end
            S_RLCHK:
            begin
                state_next = S_RL;
            end
            S_RL:
            begin
                a_next = rdata;
                if (i_reg >= used_reg || y_reg < rdata.first)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    frame_sel_next = 1'b1;
                    k_next = '0;
                    raddr = '0;
                    state_next = S_FCHK;
                end
            end
            S_RRCHK:
            begin
                state_next = S_RR;
            end
            S_RR:
            begin
                b_next = rdata;
                if (r_reg >= used_reg || (r_reg > i_reg && y_reg < rdata.first))
                begin
                    r_next = r_reg - 1'b1;
                    raddr = IdxW'(r_reg - 1'b1);
                    state_next = S_RRDEC;
                end
                else
                begin
                    state_next = S_RDEC;
                end
            end
            S_RRDEC:
            begin
                b_next = rdata;
                state_next = S_RDEC;
            end
            S_RDEC:
            begin
                if (r_reg == '1 || r_reg < i_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RWL;
                end
            end
            S_RWL:
            begin
                // l == r split
                if (i_reg == r_reg && x_reg > a_reg.first && y_reg < a_reg.last)
                begin
                    if (used_reg >= CntW'(TableDepth))
                    begin
                        status_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        w_next = a_reg;
                        w_next.first = y_reg + 1'b1;
                        wa_next = i_reg + 1'b1;
                        we = 1'b1;
                        waddr = IdxW'(i_reg);
                        wdata = a_reg;
                        wdata.last = x_reg - 1'b1;
                        mup_next = 1'b1;
                        k_next = used_reg;
                        mend_next = i_reg + 1'b1;
                        ret_next = S_WR;
                        state_next = S_MVRD;
                    end
                end
                else if ((x_reg > a_reg.first && x_reg <= a_reg.last) ||
                         (y_reg >= b_reg.first && y_reg < b_reg.last))
                begin
                    if (wmode_reg)
                    begin
                        status_next = ST_REFUSED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        if (x_reg > a_reg.first && x_reg <= a_reg.last)
                        begin
                            we = 1'b1;
                            waddr = IdxW'(i_reg);
                            wdata = a_reg;
                            wdata.last = x_reg - 1'b1;
                            i_next = i_reg + 1'b1;
                        end
                        state_next = S_RWR;
                    end
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_RWR:
            begin
                if (y_reg >= b_reg.first && y_reg < b_reg.last)
                begin
                    we = 1'b1;
                    waddr = IdxW'(r_reg);
                    wdata = b_reg;
                    wdata.first = y_reg + 1'b1;
                    r_next = r_reg - 1'b1;
                end
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                // remove l..r if any
                if (r_reg != '1 && r_reg >= i_reg)
                begin
                    mup_next = 1'b0;
                    mcnt_next = r_reg - i_reg + 1'b1;
                    k_next = i_reg;
                    ret_next = S_OUT;
                    state_next = S_MVRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            wmode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                wmode_reg <= cfg_wdata;
            end
            used_reg <= used_next;
            if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[61:31] < s_axis_tdata[30:0])
                begin
                    state_reg <= S_OUT;
                end
                else if (s_axis_tuser && used_reg == '0)
                begin
                    state_reg <= S_OUT;
                end
                else
                begin
                    state_reg <= S_FCHK;
                end
            end
            else
            begin
                state_reg <= state_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= {5'd0, used_reg, status_reg};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid && s_axis_tready)
        begin
            act_reg <= s_axis_tuser;
            x_reg <= s_axis_tdata[30:0];
            y_reg <= s_axis_tdata[61:31];
            h_reg <= s_axis_tdata[125:62];
            p_reg <= s_axis_tdata[129:126];
            f_reg <= s_axis_tdata[161:130];
            k_reg <= '0;
            frame_sel_reg <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            k_reg <= k_next;
            frame_sel_reg <= frame_sel_next;
            status_reg <= status_next;
        end
        i_reg <= i_next;
        r_reg <= r_next;
        mend_reg <= mend_next;
        mcnt_reg <= mcnt_next;
        mup_reg <= mup_next;
        ret_reg <= ret_next;
        a_reg <= a_next;
        b_reg <= b_next;
        w_reg <= w_next;
        wa_reg <= wa_next;
    end
endmodule
